// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the rate selector modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the same clock edge, switched off while reset is held.
`define STR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked on the following clock edge.
`define STR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/str_pkg.sv =====
// Types, constants and codes shared by the rate selector modules.
package str_pkg;

  localparam int NUM_MODES_DEF    = 16;
  localparam int NUM_STATIONS_DEF = 16;

  localparam int OP_W      = 2;
  localparam int MODE_W    = 4;
  localparam int STA_W     = 4;
  localparam int THR_W     = 16;
  localparam int RATE_W    = 33;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int MODE_SPAN = 2 ** MODE_W;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_DATA  = 2'd1,
    OP_RTS   = 2'd2
  } op_e;

  localparam logic [CFG_IDX_W-1:0] CFG_SUPPORTED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASIC     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT   = 2'd2;

  typedef struct packed {
    logic                    we;
    logic [MODE_W-1:0]       addr;
    logic signed [THR_W-1:0] thr;
    logic [RATE_W-1:0]       rate;
  } tbl_wr_t;

  typedef struct packed {
    logic                    start;
    logic                    rts;
    logic signed [THR_W-1:0] snr;
  } srch_req_t;

  typedef struct packed {
    logic              done;
    logic [MODE_W-1:0] mode;
  } srch_rsp_t;

endpackage

// ===== rtl/snr_threshold_rate_selector.sv =====
// Top level of the SNR threshold rate selector: control, station cache and output register.
//
//   Channel  Dir  Handshake                   Content
//   s_axis   in   s_axis_tvalid/tready        table write or rate query word
//   m_axis   out  m_axis_tvalid/tready        selected mode and cache flags
//   cfg      in   cfg_we_i                    supported mask, basic mask, default mode
//
// A table write or an unused opcode goes straight to the result state, a data query
// reads the station cache first and scans only on a miss, and an RTS query scans at once.
// The scan reads the mode table memory through its single read port, one entry per cycle.
// A word is accepted only while the control is idle; the output register holds one
// finished result, so a stalled master side keeps the following result in the control,
// which takes no new word meanwhile. Reset clears all station cache valid bits at once;
// the mode table is undefined until written.
module snr_threshold_rate_selector #(
  parameter int NUM_MODES    = str_pkg::NUM_MODES_DEF,
  parameter int NUM_STATIONS = str_pkg::NUM_STATIONS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // entry_index, entry_threshold, entry_rate, station_id, link_snr, zero fill
  input  logic [str_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // opcode
  input  logic [str_pkg::OP_W-1:0]          s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // mode_index, mcs_changed, from_cache, zero fill
  output logic [str_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [str_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [str_pkg::CFG_W-1:0]         cfg_wdata_i
);
  import str_pkg::*;

  `include "assert_macros.svh"

  localparam int SAW = (NUM_STATIONS > 1) ? $clog2(NUM_STATIONS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SEARCH,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic signed [THR_W-1:0] snr;
    logic [MODE_W-1:0]       mode;
  } cache_t;

  state_e                  state_q;
  op_e                     op_q;
  logic [SAW-1:0]          sta_q;
  logic                    range_q;
  logic signed [THR_W-1:0] snr_q;
  logic [MODE_W-1:0]       prev_q;
  logic [MODE_W-1:0]       res_mode_q;
  logic                    res_chg_q;
  logic                    res_hit_q;
  logic                    out_valid_q;
  logic [MODE_W-1:0]       out_mode_q;
  logic                    out_chg_q;
  logic                    out_hit_q;
  logic [NUM_STATIONS-1:0] vld_q;
  logic [CFG_W-1:0]        supported_q;
  logic [CFG_W-1:0]        basic_q;
  logic [MODE_W-1:0]       default_q;

  op_e                     in_op;
  logic [MODE_W-1:0]       in_idx;
  logic signed [THR_W-1:0] in_thr;
  logic [RATE_W-1:0]       in_rate;
  logic [STA_W-1:0]        in_sta;
  logic signed [THR_W-1:0] in_snr;
  logic                    in_sta_ok;
  logic                    accept;
  logic                    out_free;
  logic                    hit;
  logic                    cache_vld;
  logic                    cache_we;
  cache_t                  cache_rd;
  cache_t                  cache_wr;
  tbl_wr_t                 tbl_wr;
  srch_req_t               srch_req;
  srch_rsp_t               srch_rsp;

  assign in_op   = op_e'(s_axis_tuser);
  assign in_idx  = s_axis_tdata[3:0];
  assign in_thr  = s_axis_tdata[19:4];
  assign in_rate = s_axis_tdata[52:20];
  assign in_sta  = s_axis_tdata[56:53];
  assign in_snr  = s_axis_tdata[72:57];

  assign in_sta_ok     = int'(in_sta) < NUM_STATIONS;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign tbl_wr.we   = accept && (in_op == OP_WRITE) && (int'(in_idx) < NUM_MODES);
  assign tbl_wr.addr = in_idx;
  assign tbl_wr.thr  = in_thr;
  assign tbl_wr.rate = in_rate;

  assign cache_vld = range_q && vld_q[sta_q];
  assign hit       = cache_vld && (cache_rd.snr == snr_q);

  // RTS queries start the scan straight from the input word, data queries
  // only after the cache lookup has missed.
  assign srch_req.start = (accept && (in_op == OP_RTS)) || ((state_q == ST_LOOKUP) && !hit);
  assign srch_req.rts   = (state_q == ST_IDLE);
  assign srch_req.snr   = (state_q == ST_IDLE) ? in_snr : snr_q;

  assign cache_we      = srch_rsp.done && (op_q == OP_DATA) && range_q;
  assign cache_wr.snr  = snr_q;
  assign cache_wr.mode = srch_rsp.mode;

  str_ram #(
    .WIDTH ($bits(cache_t)),
    .DEPTH (NUM_STATIONS)
  ) u_cache_ram (
    .clk_i   (clk_i),
    .we_i    (cache_we),
    .waddr_i (sta_q),
    .wdata_i (cache_wr),
    .re_i    (accept),
    .raddr_i (SAW'(in_sta)),
    .rdata_o (cache_rd)
  );

  str_search #(
    .NUM_MODES (NUM_MODES)
  ) u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tbl_wr_i    (tbl_wr),
    .req_i       (srch_req),
    .supported_i (supported_q),
    .basic_i     (basic_q),
    .default_i   (default_q),
    .rsp_o       (srch_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_WRITE;
      sta_q       <= '0;
      range_q     <= 1'b0;
      snr_q       <= '0;
      prev_q      <= '0;
      res_mode_q  <= '0;
      res_chg_q   <= 1'b0;
      res_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_mode_q  <= '0;
      out_chg_q   <= 1'b0;
      out_hit_q   <= 1'b0;
      vld_q       <= '0;
      supported_q <= '1;
      basic_q     <= CFG_W'(1);
      default_q   <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state_q != ST_RESULT)) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SUPPORTED: supported_q <= cfg_wdata_i;
          CFG_BASIC:     basic_q     <= cfg_wdata_i;
          CFG_DEFAULT:   default_q   <= cfg_wdata_i[MODE_W-1:0];
          default: ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            op_q       <= in_op;
            sta_q      <= SAW'(in_sta);
            range_q    <= in_sta_ok;
            snr_q      <= in_snr;
            res_mode_q <= '0;
            res_chg_q  <= 1'b0;
            res_hit_q  <= 1'b0;
            unique case (in_op)
              OP_DATA: state_q <= ST_LOOKUP;
              OP_RTS:  state_q <= ST_SEARCH;
              default: state_q <= ST_RESULT;
            endcase
          end
        end
        ST_LOOKUP: begin
          prev_q <= cache_vld ? cache_rd.mode : default_q;
          if (hit) begin
            res_mode_q <= cache_rd.mode;
            res_hit_q  <= 1'b1;
            state_q    <= ST_RESULT;
          end else begin
            state_q <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (srch_rsp.done) begin
            res_mode_q <= srch_rsp.mode;
            res_chg_q  <= cache_we && (prev_q != srch_rsp.mode);
            if (cache_we) begin
              vld_q[sta_q] <= 1'b1;
            end
            state_q <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            out_mode_q  <= res_mode_q;
            out_chg_q   <= res_chg_q;
            out_hit_q   <= res_hit_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_hit_q, out_chg_q, out_mode_q};

  `STR_ASSERT_IMP(a_done_in_search, srch_rsp.done, state_q == ST_SEARCH, "Scan result out of turn.")
  `STR_ASSERT_IMP(a_hit_no_change, m_axis_tvalid, !(out_hit_q && out_chg_q), "Cached word flagged as changed.")

endmodule

// ===== rtl/str_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module str_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/str_search.sv =====
// Mode table memory and the scan unit that walks it one entry per cycle.
module str_search #(
  parameter int NUM_MODES = str_pkg::NUM_MODES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  str_pkg::tbl_wr_t            tbl_wr_i,
  input  str_pkg::srch_req_t          req_i,
  input  logic [str_pkg::CFG_W-1:0]   supported_i,
  input  logic [str_pkg::CFG_W-1:0]   basic_i,
  input  logic [str_pkg::MODE_W-1:0]  default_i,
  output str_pkg::srch_rsp_t          rsp_o
);
  import str_pkg::*;

  `include "assert_macros.svh"

  localparam int MODE_LIMIT = (NUM_MODES < MODE_SPAN) ? NUM_MODES : MODE_SPAN;
  localparam int TAW = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1;
  localparam int CW = $clog2(MODE_LIMIT + 1);

  logic                    busy_q;
  logic                    rts_q;
  logic signed [THR_W-1:0] snr_q;
  logic [CW-1:0]           cnt_q;
  logic                    vld_q;
  logic [MODE_W-1:0]       m_q;
  logic [MODE_W-1:0]       best_mode_q;
  logic [RATE_W-1:0]       best_rate_q;
  logic signed [THR_W-1:0] best_thr_q;

  logic                      issue;
  logic                      take;
  logic                      done;
  logic [THR_W+RATE_W-1:0]   rdata;
  logic signed [THR_W-1:0]   rd_thr;
  logic [RATE_W-1:0]         rd_rate;

  str_ram #(
    .WIDTH (THR_W + RATE_W),
    .DEPTH (NUM_MODES)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_wr_i.we),
    .waddr_i (TAW'(tbl_wr_i.addr)),
    .wdata_i ({tbl_wr_i.rate, tbl_wr_i.thr}),
    .re_i    (issue),
    .raddr_i (TAW'(cnt_q)),
    .rdata_o (rdata)
  );

  assign rd_thr  = rdata[THR_W-1:0];
  assign rd_rate = rdata[THR_W +: RATE_W];

  assign issue = busy_q && (cnt_q != CW'(MODE_LIMIT));
  assign done  = busy_q && !issue && !vld_q;

  // Data queries keep the fastest qualifying mode other than mode zero; RTS
  // queries keep the basic mode with the highest positive threshold.
  always_comb begin
    if (rts_q) begin
      take = vld_q && basic_i[m_q] && (rd_thr > best_thr_q) && (rd_thr < snr_q);
    end else begin
      take = vld_q && (m_q != '0) && supported_i[m_q] &&
             (rd_rate > best_rate_q) && (rd_thr < snr_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rts_q       <= 1'b0;
      snr_q       <= '0;
      cnt_q       <= '0;
      vld_q       <= 1'b0;
      m_q         <= '0;
      best_mode_q <= '0;
      best_rate_q <= '0;
      best_thr_q  <= '0;
    end else if (req_i.start) begin
      busy_q      <= 1'b1;
      rts_q       <= req_i.rts;
      snr_q       <= req_i.snr;
      cnt_q       <= '0;
      vld_q       <= 1'b0;
      best_mode_q <= default_i;
      best_rate_q <= '0;
      best_thr_q  <= '0;
    end else if (busy_q) begin
      vld_q <= issue;
      if (issue) begin
        m_q   <= MODE_W'(cnt_q);
        cnt_q <= cnt_q + CW'(1);
      end
      if (take) begin
        best_mode_q <= m_q;
        best_rate_q <= rd_rate;
        best_thr_q  <= rd_thr;
      end
      if (done) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign rsp_o.done = done;
  assign rsp_o.mode = best_mode_q;

  `STR_ASSERT_IMP(a_start_when_free, req_i.start, !busy_q, "Scan started while busy.")
  `STR_ASSERT_NXT(a_done_frees, done && !req_i.start, !busy_q && !vld_q, "Scan did not end.")

endmodule

// ===== tb/snr_threshold_rate_selector_tb.sv =====
// Testbench for the SNR threshold rate selector: directed and random words checked by a scoreboard.
module snr_threshold_rate_selector_tb;
  import str_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic              cached;
    logic              changed;
    logic [MODE_W-1:0] mode;
  } verdict_t;

  class rate_choice_board;
    logic signed [THR_W-1:0] thr_tab[MODE_SPAN];
    logic [RATE_W-1:0]       rate_tab[MODE_SPAN];
    bit                      cache_ok[NUM_STATIONS_DEF];
    logic signed [THR_W-1:0] cache_snr[NUM_STATIONS_DEF];
    logic [MODE_W-1:0]       cache_mode[NUM_STATIONS_DEF];
    logic [CFG_W-1:0]        supported;
    logic [CFG_W-1:0]        basic;
    logic [MODE_W-1:0]       fallback;
    verdict_t                expected[$];
    int                      mismatches;

    function new();
      foreach (thr_tab[m]) begin
        thr_tab[m] = '0;
        rate_tab[m] = '0;
      end
      foreach (cache_ok[s]) begin
        cache_ok[s] = 1'b0;
        cache_snr[s] = '0;
        cache_mode[s] = '0;
      end
      supported = 16'hFFFF;
      basic = 16'h0001;
      fallback = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_SUPPORTED: supported = val;
        CFG_BASIC:     basic = val;
        CFG_DEFAULT:   fallback = val[MODE_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [MODE_W-1:0] data_choice(logic signed [THR_W-1:0] snr);
      logic [MODE_W-1:0] best;
      logic [RATE_W-1:0] best_rate;
      best = fallback;
      best_rate = '0;
      for (int m = 1; m < MODE_SPAN; m++) begin
        if (supported[m] && rate_tab[m] > best_rate && thr_tab[m] < snr) begin
          best_rate = rate_tab[m];
          best = MODE_W'(m);
        end
      end
      return best;
    endfunction

    function logic [MODE_W-1:0] rts_choice(logic signed [THR_W-1:0] snr);
      logic [MODE_W-1:0]       best;
      logic signed [THR_W-1:0] best_thr;
      best = fallback;
      best_thr = '0;
      for (int m = 0; m < MODE_SPAN; m++) begin
        if (basic[m] && thr_tab[m] > best_thr && thr_tab[m] < snr) begin
          best_thr = thr_tab[m];
          best = MODE_W'(m);
        end
      end
      return best;
    endfunction

    function void note_word(logic [OP_W-1:0] op, logic [IN_TDATA_W-1:0] data);
      logic [MODE_W-1:0]       idx;
      logic [STA_W-1:0]        sta;
      logic signed [THR_W-1:0] thr;
      logic signed [THR_W-1:0] snr;
      logic [RATE_W-1:0]       rate;
      logic [MODE_W-1:0]       prev;
      verdict_t                v;
      idx = data[3:0];
      thr = data[19:4];
      rate = data[52:20];
      sta = data[56:53];
      snr = data[72:57];
      v = '0;
      case (op)
        OP_WRITE: begin
          thr_tab[idx] = thr;
          rate_tab[idx] = rate;
        end
        OP_DATA: begin
          if (cache_ok[sta] && cache_snr[sta] == snr) begin
            v.mode = cache_mode[sta];
            v.cached = 1'b1;
          end else begin
            prev = cache_ok[sta] ? cache_mode[sta] : fallback;
            v.mode = data_choice(snr);
            cache_ok[sta] = 1'b1;
            cache_snr[sta] = snr;
            cache_mode[sta] = v.mode;
            v.changed = (prev != v.mode);
          end
        end
        OP_RTS: v.mode = rts_choice(snr);
        default: ;
      endcase
      expected.insert(expected.size(), v);
    endfunction

    function void check_word(logic [OUT_TDATA_W-1:0] data);
      verdict_t want;
      verdict_t got;
      got = data[5:0];
      if (expected.size() == 0) begin
        mismatches++;
        $display("%0t: result word %h arrived with nothing expected", $time, data);
        return;
      end
      want = expected.pop_front();
      if (got.mode !== want.mode || got.changed !== want.changed || got.cached !== want.cached)
      begin
        mismatches++;
        $display("%0t: expected mode %0d changed %0b cached %0b, got mode %0d changed %0b cached %0b",
                 $time, want.mode, want.changed, want.cached, got.mode, got.changed, got.cached);
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [OP_W-1:0]        s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_W-1:0]       cfg_wdata_i;

  rate_choice_board        board = new();
  bit                      calm = 1'b0;
  logic signed [THR_W-1:0] level_pool[8];

  snr_threshold_rate_selector u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [THR_W-1:0] pick_level();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return level_pool[$urandom_range(0, 7)];
      5, 6, 7: begin
        v = int'($urandom_range(0, 10240)) - 2560;
        return v[15:0];
      end
      8: return THR_W'($urandom);
      default: begin
        case ($urandom_range(0, 2))
          0: return 16'h8000;
          1: return 16'h7FFF;
          default: return 16'h0000;
        endcase
      end
    endcase
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_word(logic [MODE_W-1:0] idx,
                                                       logic signed [THR_W-1:0] thr,
                                                       logic [RATE_W-1:0] rate,
                                                       logic [STA_W-1:0] sta,
                                                       logic signed [THR_W-1:0] snr);
    return {7'd0, snr, sta, rate, thr, idx};
  endfunction

  task automatic send_word(input logic [OP_W-1:0] op, input logic [IN_TDATA_W-1:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_word(op, data);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.expected.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [CFG_W-1:0] sup, input logic [CFG_W-1:0] bas,
                               input logic [MODE_W-1:0] dflt);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_SUPPORTED;
    cfg_wdata_i <= sup;
    @(posedge clk_i);
    board.set_reg(CFG_SUPPORTED, sup);
    cfg_idx_i <= CFG_BASIC;
    cfg_wdata_i <= bas;
    @(posedge clk_i);
    board.set_reg(CFG_BASIC, bas);
    cfg_idx_i <= CFG_DEFAULT;
    cfg_wdata_i <= {12'd0, dflt};
    @(posedge clk_i);
    board.set_reg(CFG_DEFAULT, {12'd0, dflt});
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int stall;
    stall = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) board.check_word(m_axis_tdata);
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        stall = pick_gap();
        m_axis_tready <= (stall == 0);
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic signed [THR_W-1:0] thr;
    logic [RATE_W-1:0]       rate;
    logic [63:0]             wide;
    logic [OP_W-1:0]         op;
    int                      r;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_wdata_i <= '0;
    foreach (level_pool[i]) level_pool[i] = THR_W'(int'($urandom_range(0, 10240)) - 2560);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int m = 0; m < MODE_SPAN; m++) begin
      if (m == 0) thr = 16'h8000;
      else if (m == MODE_SPAN - 1) thr = 16'h7FFF;
      else thr = THR_W'(m * 512 - 1024);
      if (m == MODE_SPAN - 1) rate = '1;
      else if (m == 5) rate = 33'h1_0000_0000;
      else rate = RATE_W'(m) * 33'd1000000;
      send_word(OP_WRITE, pack_word(MODE_W'(m), thr, rate, 4'd0, 16'sd0));
    end
    send_word(OP_DATA, pack_word(4'd0, 16'sd0, 33'd0, 4'd0, 16'h8000));
    send_word(OP_DATA, pack_word(4'd0, 16'sd0, 33'd0, 4'd0, 16'h7FFF));
    send_word(OP_DATA, pack_word(4'd0, 16'sd0, 33'd0, 4'd0, 16'h7FFF));
    send_word(OP_DATA, pack_word(4'd0, 16'sd0, 33'd0, 4'd15, 16'sd1000));
    send_word(OP_RTS, pack_word(4'd0, 16'sd0, 33'd0, 4'd0, 16'h7FFF));
    send_word(OP_UNUSED, pack_word(4'd15, 16'h7FFF, '1, 4'd15, 16'h7FFF));
    send_word(OP_DATA, pack_word(4'd0, 16'sd0, 33'd0, 4'd1, 16'sd0));
    send_word(OP_RTS, pack_word(4'd0, 16'sd0, 33'd0, 4'd0, 16'h8000));
    send_word(OP_DATA, pack_word(4'd0, 16'sd0, 33'd0, 4'd15, 16'sd1000));

    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: apply_setting(16'hFFFF, 16'h0001, 4'd0);
        1: apply_setting(16'h0000, 16'h0000, 4'd15);
        2: apply_setting(16'hFFFF, 16'hFFFF, 4'd15);
        3: apply_setting(16'h0001, 16'hFFFF, 4'd0);
        default: apply_setting(CFG_W'($urandom), CFG_W'($urandom), MODE_W'($urandom));
      endcase
      calm = (p == 2);
      for (int i = 0; i < 100; i++) begin
        r = $urandom_range(0, 99);
        if (r < 20) op = OP_WRITE;
        else if (r < 72) op = OP_DATA;
        else if (r < 95) op = OP_RTS;
        else op = OP_UNUSED;
        case ($urandom_range(0, 9))
          0: rate = '0;
          1: rate = '1;
          2, 3, 4, 5: rate = RATE_W'($urandom_range(1, 12)) * 33'd1000000;
          default: begin
            wide = {$urandom, $urandom};
            rate = wide[RATE_W-1:0];
          end
        endcase
        send_word(op, pack_word(MODE_W'($urandom), pick_level(), rate, STA_W'($urandom),
                                pick_level()));
      end
    end
    calm = 1'b0;
    settle();
    repeat (25) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
